FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Constants and shared types of the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  // Width of a 32x32 product after the fractional bits are floored away.
  localparam int PROD_W    = 64 - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;

  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = 32 / SQ_STEPS;

  localparam int MAG_W     = 33;
  localparam int DEN_W     = 33;
  localparam int DV_STEPS  = 4;
  localparam int DVD_W     = ((MAG_W + 3 + FRAC_BITS + DV_STEPS - 1) / DV_STEPS) * DV_STEPS;
  localparam int DV_STAGES = DVD_W / DV_STEPS;

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

  localparam logic MODE_RAY    = 1'b0;
  localparam logic MODE_NORMAL = 1'b1;

  localparam logic [2:0] REG_R0_C01 = 3'd0;
  localparam logic [2:0] REG_R0_C23 = 3'd1;
  localparam logic [2:0] REG_R1_C01 = 3'd2;
  localparam logic [2:0] REG_R1_C23 = 3'd3;
  localparam logic [2:0] REG_R2_C01 = 3'd4;
  localparam logic [2:0] REG_R2_C23 = 3'd5;

  // Travels beside the square root: a/h/c in ray mode, the normal otherwise.
  typedef struct packed {
    logic               mode;
    logic               miss;
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
  } sq_side_t;

  // Travels beside the divider lanes.
  typedef struct packed {
    logic       mode;
    logic       hit;
    logic [2:0] neg;
  } dv_side_t;

endpackage

FILE: hw/rtl/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root of a 64-bit value, two radicand bits per step.
// ----------------------------------------------------------------------------
module rsi_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [63:0]       in_rad,
  input  rsi_pkg::sq_side_t in_side,
  output logic              out_vld,
  output logic [31:0]       out_root,
  output rsi_pkg::sq_side_t out_side
);
  import rsi_pkg::*;

  logic        vld_r  [0:SQ_STAGES-1];
  logic [63:0] rad_r  [0:SQ_STAGES-1];
  logic [34:0] rem_r  [0:SQ_STAGES-1];
  logic [31:0] root_r [0:SQ_STAGES-1];
  sq_side_t    side_r [0:SQ_STAGES-1];

  logic        vld_in  [0:SQ_STAGES-1];
  logic [63:0] rad_in  [0:SQ_STAGES-1];
  logic [34:0] rem_in  [0:SQ_STAGES-1];
  logic [31:0] root_in [0:SQ_STAGES-1];
  sq_side_t    side_in [0:SQ_STAGES-1];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [63:0] rad_nxt;
    logic [34:0] rem_nxt;
    logic [31:0] root_nxt;

    if (g == 0) begin : g_first
      assign vld_in[g]  = in_vld;
      assign rad_in[g]  = in_rad;
      assign rem_in[g]  = '0;
      assign root_in[g] = '0;
      assign side_in[g] = in_side;
    end else begin : g_next
      assign vld_in[g]  = vld_r[g-1];
      assign rad_in[g]  = rad_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign root_in[g] = root_r[g-1];
      assign side_in[g] = side_r[g-1];
    end

    always_comb begin : step
      logic [34:0] cur;
      logic [34:0] trial;
      rad_nxt  = rad_in[g];
      rem_nxt  = rem_in[g];
      root_nxt = root_in[g];
      for (int j = 0; j < SQ_STEPS; j++) begin
        cur   = {rem_nxt[32:0], rad_nxt[63:62]};
        trial = {1'b0, root_nxt, 2'b01};
        if (cur >= trial) begin
          rem_nxt  = cur - trial;
          root_nxt = {root_nxt[30:0], 1'b1};
        end else begin
          rem_nxt  = cur;
          root_nxt = {root_nxt[30:0], 1'b0};
        end
        rad_nxt = {rad_nxt[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g]  <= rad_nxt;
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        side_r[g] <= side_in[g];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];
  assign out_side = side_r[SQ_STAGES-1];

endmodule

FILE: hw/rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Three-lane pipelined restoring divider sharing one divisor.
// ----------------------------------------------------------------------------
module rsi_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [2:0][rsi_pkg::DVD_W-1:0]     in_dvd,
  input  logic [rsi_pkg::DEN_W-1:0]          in_den,
  input  rsi_pkg::dv_side_t                  in_side,
  output logic                               out_vld,
  output logic [2:0][rsi_pkg::DVD_W-1:0]     out_quo,
  output rsi_pkg::dv_side_t                  out_side
);
  import rsi_pkg::*;

  // The dividend register shifts left and collects quotient bits at the bottom.
  logic                         vld_r [0:DV_STAGES-1];
  logic [2:0][DVD_W-1:0]        dvd_r [0:DV_STAGES-1];
  logic [2:0][DEN_W-1:0]        rem_r [0:DV_STAGES-1];
  logic [DEN_W-1:0]             den_r [0:DV_STAGES-1];
  dv_side_t                     side_r [0:DV_STAGES-1];

  logic                         vld_in [0:DV_STAGES-1];
  logic [2:0][DVD_W-1:0]        dvd_in [0:DV_STAGES-1];
  logic [2:0][DEN_W-1:0]        rem_in [0:DV_STAGES-1];
  logic [DEN_W-1:0]             den_in [0:DV_STAGES-1];
  dv_side_t                     side_in [0:DV_STAGES-1];

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
    logic [2:0][DVD_W-1:0] dvd_nxt;
    logic [2:0][DEN_W-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign vld_in[g]  = in_vld;
      assign dvd_in[g]  = in_dvd;
      assign rem_in[g]  = '0;
      assign den_in[g]  = in_den;
      assign side_in[g] = in_side;
    end else begin : g_next
      assign vld_in[g]  = vld_r[g-1];
      assign dvd_in[g]  = dvd_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign den_in[g]  = den_r[g-1];
      assign side_in[g] = side_r[g-1];
    end

    always_comb begin : step
      logic [DEN_W:0] cur;
      logic           qbit;
      dvd_nxt = dvd_in[g];
      rem_nxt = rem_in[g];
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < DV_STEPS; j++) begin
          cur  = {rem_nxt[l], dvd_nxt[l][DVD_W-1]};
          qbit = (cur >= {1'b0, den_in[g]});
          if (qbit) begin
            rem_nxt[l] = DEN_W'(cur - {1'b0, den_in[g]});
          end else begin
            rem_nxt[l] = cur[DEN_W-1:0];
          end
          dvd_nxt[l] = {dvd_nxt[l][DVD_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[g]  <= dvd_nxt;
        rem_r[g]  <= rem_nxt;
        den_r[g]  <= den_in[g];
        side_r[g] <= side_in[g];
      end
    end
  end

  assign out_vld  = vld_r[DV_STAGES-1];
  assign out_quo  = dvd_r[DV_STAGES-1];
  assign out_side = side_r[DV_STAGES-1];

endmodule

FILE: hw/rtl/ray_sphere_intersect_normal.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_normal
// Ray / transformed unit sphere intersection and surface normal, Q16.16.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled and
// returns exactly one result per transaction, in order. The pipeline holds
// seven stages of matrix, dot product and discriminant arithmetic, eight
// stages of square root at four bits of root each, one stage of divider
// setup, thirteen stages of divider at four quotient bits each, and the
// output register. A stall on the result side freezes the whole pipeline and
// stalls the input. The user must write the inverse matrix through the
// configuration port only while no transaction is in flight; the block does
// not enforce this. Reset loads the identity.
module ray_sphere_intersect_normal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_t_near,
  output logic signed [31:0] out_t_far,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z
);
  import rsi_pkg::*;

  function automatic logic signed [PROD_W-1:0] fmul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = a * b;
    return pr[63:FRAC_BITS];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF});
    lo = $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_p(input logic signed [PROD_W-1:0] v);
    return $signed({{(SUM_W-PROD_W){v[PROD_W-1]}}, v});
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_w(input logic signed [31:0] v);
    return $signed({{(SUM_W-32){v[31]}}, v});
  endfunction

  function automatic logic [31:0] qsat(input logic [DVD_W-1:0] q, input logic neg);
    logic [DVD_W-1:0] lim;
    logic [DVD_W-1:0] nq;
    lim = DVD_W'(64'h8000_0000);
    nq  = -q;
    if (neg) begin
      return (q > lim) ? 32'h8000_0000 : nq[31:0];
    end
    return (q >= lim) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Inverse matrix, column 3 is the translation.
  logic signed [31:0] m_r [0:2][0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 4; k++) begin
          m_r[r][k] <= (r == k) ? ONE_FX : '0;
        end
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_R0_C01: begin
          m_r[0][0] <= cfg_data[63:32];
          m_r[0][1] <= cfg_data[31:0];
        end
        REG_R0_C23: begin
          m_r[0][2] <= cfg_data[63:32];
          m_r[0][3] <= cfg_data[31:0];
        end
        REG_R1_C01: begin
          m_r[1][0] <= cfg_data[63:32];
          m_r[1][1] <= cfg_data[31:0];
        end
        REG_R1_C23: begin
          m_r[1][2] <= cfg_data[63:32];
          m_r[1][3] <= cfg_data[31:0];
        end
        REG_R2_C01: begin
          m_r[2][0] <= cfg_data[63:32];
          m_r[2][1] <= cfg_data[31:0];
        end
        REG_R2_C23: begin
          m_r[2][2] <= cfg_data[63:32];
          m_r[2][3] <= cfg_data[31:0];
        end
        default: ;
      endcase
    end
  end

  // Valid bits of stages 1 to 8.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Stage 1: input capture.
  logic               mode1_r;
  logic signed [31:0] p1_r [0:2];
  logic signed [31:0] d1_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      p1_r[0] <= in_origin_x;
      p1_r[1] <= in_origin_y;
      p1_r[2] <= in_origin_z;
      d1_r[0] <= in_dir_x;
      d1_r[1] <= in_dir_y;
      d1_r[2] <= in_dir_z;
    end
  end

  // Stage 2: matrix products for the point and the direction.
  logic                     mode2_r;
  logic signed [PROD_W-1:0] pp2_r [0:2][0:2];
  logic signed [PROD_W-1:0] pd2_r [0:2][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= mode1_r;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pp2_r[r][k] <= fmul(m_r[r][k], p1_r[k]);
          pd2_r[r][k] <= fmul(m_r[r][k], d1_r[k]);
        end
      end
    end
  end

  // Stage 3: object-space point and direction.
  logic               mode3_r;
  logic signed [31:0] po3_r [0:2];
  logic signed [31:0] dd3_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      mode3_r <= mode2_r;
      for (int r = 0; r < 3; r++) begin
        po3_r[r] <= sat32(sx_w(m_r[r][3]) + sx_p(pp2_r[r][0]) + sx_p(pp2_r[r][1])
                          + sx_p(pp2_r[r][2]));
        dd3_r[r] <= sat32(sx_p(pd2_r[r][0]) + sx_p(pd2_r[r][1]) + sx_p(pd2_r[r][2]));
      end
    end
  end

  // Stage 4: dot products in ray mode, transposed matrix products otherwise.
  logic signed [31:0]       opa [0:8];
  logic signed [31:0]       opb [0:8];
  logic                     mode4_r;
  logic signed [PROD_W-1:0] q4_r [0:8];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (mode3_r == MODE_RAY) begin
        opa[j]     = dd3_r[j];
        opb[j]     = dd3_r[j];
        opa[3 + j] = dd3_r[j];
        opb[3 + j] = po3_r[j];
        opa[6 + j] = po3_r[j];
        opb[6 + j] = po3_r[j];
      end else begin
        for (int k = 0; k < 3; k++) begin
          opa[3 * j + k] = m_r[k][j];
          opb[3 * j + k] = po3_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode4_r <= mode3_r;
      for (int j = 0; j < 9; j++) begin
        q4_r[j] <= fmul(opa[j], opb[j]);
      end
    end
  end

  // Stage 5: a, h, c in ray mode; the unnormalized normal otherwise.
  logic signed [31:0]      cdot;
  logic signed [SUM_W-1:0] cm;
  logic                    mode5_r;
  logic signed [31:0]      x5_r [0:2];

  always_comb begin
    cdot = sat32(sx_p(q4_r[6]) + sx_p(q4_r[7]) + sx_p(q4_r[8]));
    cm   = sx_w(cdot) - sx_w(ONE_FX);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode5_r <= mode4_r;
      x5_r[0] <= sat32(sx_p(q4_r[0]) + sx_p(q4_r[1]) + sx_p(q4_r[2]));
      x5_r[1] <= sat32(sx_p(q4_r[3]) + sx_p(q4_r[4]) + sx_p(q4_r[5]));
      x5_r[2] <= (mode4_r == MODE_RAY) ? sat32(cm) : cdot;
    end
  end

  // Stage 6: h*h and a*c, or the three squares.
  logic               mode6_r;
  logic signed [31:0] x6_r [0:2];
  logic signed [63:0] m6_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      mode6_r <= mode5_r;
      x6_r    <= x5_r;
      if (mode5_r == MODE_RAY) begin
        m6_r[0] <= x5_r[1] * x5_r[1];
        m6_r[1] <= x5_r[0] * x5_r[2];
      end else begin
        m6_r[0] <= x5_r[0] * x5_r[0];
        m6_r[1] <= x5_r[1] * x5_r[1];
      end
      m6_r[2] <= x5_r[2] * x5_r[2];
    end
  end

  // Stage 7: radicand (quarter discriminant or squared length).
  logic [64:0] qd;
  logic [63:0] rad7_r;
  sq_side_t    side7_r;

  assign qd = {m6_r[0][63], m6_r[0]} - {m6_r[1][63], m6_r[1]};

  always_ff @(posedge clk) begin
    if (en) begin
      side7_r.mode <= mode6_r;
      side7_r.x0   <= x6_r[0];
      side7_r.x1   <= x6_r[1];
      side7_r.x2   <= x6_r[2];
      if (mode6_r == MODE_RAY) begin
        rad7_r       <= qd[63:0];
        side7_r.miss <= qd[64] || (x6_r[0] == '0);
      end else begin
        rad7_r       <= m6_r[0] + m6_r[1] + m6_r[2];
        side7_r.miss <= 1'b0;
      end
    end
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v7_r),
    .in_rad   (rad7_r),
    .in_side  (side7_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Stage 8: signed numerators become magnitudes scaled by one.
  logic signed [33:0]    num [0:2];
  logic signed [33:0]    hx;
  logic signed [33:0]    sx;
  logic [33:0]           mag [0:2];
  logic [2:0][DVD_W-1:0] dvd8_r;
  logic [DEN_W-1:0]      den8_r;
  dv_side_t              side8_r;

  always_comb begin
    hx = $signed({{2{sq_side.x1[31]}}, sq_side.x1});
    sx = $signed({2'b00, sq_root});
    if (sq_side.mode == MODE_RAY) begin
      num[0] = -hx - sx;
      num[1] = -hx + sx;
      num[2] = '0;
    end else begin
      num[0] = $signed({{2{sq_side.x0[31]}}, sq_side.x0});
      num[1] = hx;
      num[2] = $signed({{2{sq_side.x2[31]}}, sq_side.x2});
    end
    for (int l = 0; l < 3; l++) begin
      mag[l] = num[l][33] ? 34'(-num[l]) : 34'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        dvd8_r[l]      <= {{(DVD_W-MAG_W-FRAC_BITS){1'b0}}, mag[l][MAG_W-1:0],
                           {FRAC_BITS{1'b0}}};
        side8_r.neg[l] <= num[l][33];
      end
      side8_r.mode <= sq_side.mode;
      if (sq_side.mode == MODE_RAY) begin
        den8_r      <= {1'b0, sq_side.x0};
        side8_r.hit <= !sq_side.miss;
      end else begin
        den8_r      <= {1'b0, sq_root};
        side8_r.hit <= (sq_root != '0);
      end
    end
  end

  logic                  dv_vld;
  logic [2:0][DVD_W-1:0] dv_quo;
  dv_side_t              dv_side;

  rsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_dvd   (dvd8_r),
    .in_den   (den8_r),
    .in_side  (side8_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // Output register.
  logic               out_valid_r;
  logic               hit_r;
  logic signed [31:0] t_near_r, t_far_r, nx_r, ny_r, nz_r;
  logic [31:0]        r0, r1, r2;

  always_comb begin
    r0 = qsat(dv_quo[0], dv_side.neg[0]);
    r1 = qsat(dv_quo[1], dv_side.neg[1]);
    r2 = qsat(dv_quo[2], dv_side.neg[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= dv_side.hit;
      t_near_r <= '0;
      t_far_r  <= '0;
      nx_r     <= '0;
      ny_r     <= '0;
      nz_r     <= '0;
      if (dv_side.hit) begin
        if (dv_side.mode == MODE_RAY) begin
          t_near_r <= r0;
          t_far_r  <= r1;
        end else begin
          nx_r <= r0;
          ny_r <= r1;
          nz_r <= r2;
        end
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_t_near   = t_near_r;
  assign out_t_far    = t_far_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_normal_z = nz_r;

endmodule

FILE: hw/rtl/rsi_chk.sv
// ----------------------------------------------------------------------------
// rsi_chk
// Port-level checks of the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_hit,
  input logic signed [31:0] out_t_near,
  input logic signed [31:0] out_t_far,
  input logic signed [31:0] out_normal_x,
  input logic signed [31:0] out_normal_y,
  input logic signed [31:0] out_normal_z
);

  // A held result transaction keeps its payload.
  `RSI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit) && $stable(out_t_near) && $stable(out_t_far) && $stable(out_normal_x) && $stable(out_normal_y) && $stable(out_normal_z), "held result changed")

  // The input only backs up behind a stalled result.
  `RSI_ASSERT_IMP(a_in_stall, in_stall, out_valid && out_stall, "input stalled without output stall")

  // A miss or zero normal carries all-zero fields.
  `RSI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_t_near == 0 && out_t_far == 0 && out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0, "miss with nonzero fields")

  // A result carries either roots or a normal, never both.
  `RSI_ASSERT_IMP(a_one_kind, out_valid, (out_t_near == 0 && out_t_far == 0) || (out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0), "roots and normal both set")

  // Roots come out ordered.
  `RSI_ASSERT_IMP(a_root_order, out_valid, out_t_near <= out_t_far, "near root above far root")

endmodule

bind ray_sphere_intersect_normal rsi_chk u_rsi_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_hit      (out_hit),
  .out_t_near   (out_t_near),
  .out_t_far    (out_t_far),
  .out_normal_x (out_normal_x),
  .out_normal_y (out_normal_y),
  .out_normal_z (out_normal_z)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks ray / unit sphere intersection and surface normal results against a
// bit-exact fixed point predictor, under random idling and long output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import rsi_pkg::*;

  typedef struct {
    logic               mode;
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_item_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] t_near, t_far, nx, ny, nz;
  } hit_result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic signed [31:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [31:0] in_dir_x, in_dir_y, in_dir_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic signed [31:0] out_t_near, out_t_far;
  logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;

  ray_sphere_intersect_normal dut (.*);

  // Shadow copy of the inverse matrix, rows by columns.
  longint      inv_mat[3][4];
  hit_result_t pending_results[$];
  int          error_count;
  int          sent_count;
  int          checked_count;
  int          hit_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint fx_div(longint num, longint den);
    return sat32((num * (64'sd1 <<< FRAC_BITS)) / den);
  endfunction

  function automatic hit_result_t compute_intersection(ray_item_t it);
    hit_result_t     r;
    longint          p[3], d[3], po[3], dd[3], n[3];
    longint          s, a, h, c, q, len, root;
    longint unsigned sum;
    p = '{it.ox, it.oy, it.oz};
    d = '{it.dx, it.dy, it.dz};
    r = '{hit: 1'b0, t_near: 0, t_far: 0, nx: 0, ny: 0, nz: 0};
    for (int i = 0; i < 3; i++) begin
      s = inv_mat[i][3];
      for (int k = 0; k < 3; k++) s += (inv_mat[i][k] * p[k]) >>> FRAC_BITS;
      po[i] = sat32(s);
    end
    if (it.mode == MODE_RAY) begin
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += (inv_mat[i][k] * d[k]) >>> FRAC_BITS;
        dd[i] = sat32(s);
      end
      a = 0; h = 0; c = 0;
      for (int i = 0; i < 3; i++) begin
        a += (dd[i] * dd[i]) >>> FRAC_BITS;
        h += (dd[i] * po[i]) >>> FRAC_BITS;
        c += (po[i] * po[i]) >>> FRAC_BITS;
      end
      a = sat32(a);
      h = sat32(h);
      c = sat32(sat32(c) - (64'sd1 <<< FRAC_BITS));
      q = h * h - a * c;
      if (q >= 0 && a != 0) begin
        root     = longint'(floor_sqrt(q));
        r.hit    = 1'b1;
        r.t_near = fx_div(-h - root, a);
        r.t_far  = fx_div(-h + root, a);
      end
    end else begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += (inv_mat[k][i] * po[k]) >>> FRAC_BITS;
        n[i] = sat32(s);
        sum += longint'(n[i] < 0 ? -n[i] : n[i]) * longint'(n[i] < 0 ? -n[i] : n[i]);
      end
      len = longint'(floor_sqrt(sum));
      if (len != 0) begin
        r.hit = 1'b1;
        r.nx  = fx_div(n[0], len);
        r.ny  = fx_div(n[1], len);
        r.nz  = fx_div(n[2], len);
      end
    end
    return r;
  endfunction

  // Mostly modest coordinates near the sphere, with occasional full-range values.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(32'h0003ffff)) - 32'sh00020000;
      default: return $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_mat_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_matrix_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_R2_C23) begin
      inv_mat[idx >> 1][(idx & 1) * 2]     = longint'($signed(data[63:32]));
      inv_mat[idx >> 1][(idx & 1) * 2 + 1] = longint'($signed(data[31:0]));
    end
    @(posedge clk);
  endtask

  task automatic load_matrix(logic signed [31:0] m[3][4]);
    wait_idle();
    for (int r = 0; r < 3; r++) begin
      write_matrix_reg(3'(2 * r), {m[r][0], m[r][1]});
      write_matrix_reg(3'(2 * r + 1), {m[r][2], m[r][3]});
    end
  endtask

  task automatic send_ray(ray_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= it.mode;
    in_origin_x <= it.ox;
    in_origin_y <= it.oy;
    in_origin_z <= it.oz;
    in_dir_x    <= it.dx;
    in_dir_y    <= it.dy;
    in_dir_z    <= it.dz;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compute_intersection(it));
    sent_count++;
  endtask

  task automatic send_fields(logic mode, logic signed [31:0] ox, oy, oz, dx, dy, dz);
    ray_item_t it;
    it = '{mode: mode, ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz};
    send_ray(it);
  endtask

  task automatic send_random(int count);
    ray_item_t it;
    for (int i = 0; i < count; i++) begin
      it.mode = $urandom_range(1);
      it.ox = rand_coord(); it.oy = rand_coord(); it.oz = rand_coord();
      it.dx = rand_coord(); it.dy = rand_coord(); it.dz = rand_coord();
      send_ray(it);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result checking.
  always @(posedge clk) begin
    hit_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        checked_count++;
        if (e.hit) hit_count++;
        if (out_hit !== e.hit || out_t_near !== e.t_near || out_t_far !== e.t_far ||
            out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz) begin
          $display("%0t: mismatch expected hit=%0d tn=%0d tf=%0d n=(%0d %0d %0d)",
                   $realtime, e.hit, e.t_near, e.t_far, e.nx, e.ny, e.nz);
          $display("%0t:          actual hit=%0d tn=%0d tf=%0d n=(%0d %0d %0d)",
                   $realtime, out_hit, out_t_near, out_t_far,
                   out_normal_x, out_normal_y, out_normal_z);
          error_count++;
        end
      end
    end
  end

  // Output stall generation, with an optional long hold.
  always @(posedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_identity_directed();
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = ONE_FX;
    // Ray through the center, a miss, a tangent ray and a zero direction.
    send_fields(MODE_RAY, 0, 0, -5 * ONE, 0, 0, ONE);
    send_fields(MODE_RAY, 0, 2 * ONE, -5 * ONE, 0, 0, ONE);
    send_fields(MODE_RAY, ONE, 0, -5 * ONE, 0, 0, ONE);
    send_fields(MODE_RAY, 0, 0, -5 * ONE, 0, 0, 0);
    send_fields(MODE_RAY, 0, 0, 0, ONE, ONE, ONE);
    send_fields(MODE_RAY, 0, 0, 0, 1, 0, 0);
    send_fields(MODE_RAY, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_fields(MODE_RAY, MINV, MINV, MINV, MINV, MINV, MINV);
    send_fields(MODE_RAY, MAXV, MINV, 0, MINV, MAXV, -1);
    send_fields(MODE_RAY, -1, -1, -1, -1, -1, -1);
    // Normals, including a zero-length one at the center.
    send_fields(MODE_NORMAL, ONE, 0, 0, MAXV, MINV, 0);
    send_fields(MODE_NORMAL, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_NORMAL, 1, 0, 0, 0, 0, 0);
    send_fields(MODE_NORMAL, MAXV, MAXV, MAXV, 0, 0, 0);
    send_fields(MODE_NORMAL, MINV, MINV, MINV, -1, -1, -1);
    send_fields(MODE_NORMAL, -ONE, ONE, -ONE, 0, 0, 0);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_register_writes();
    logic signed [31:0] m[3][4];
    // Scaled, translated sphere; then out-of-range indexes must be ignored.
    m = '{'{32'sh00008000, 0, 0, 32'sh00010000},
          '{0, 32'sh00020000, 0, 0},
          '{0, 32'sh00004000, 32'sh00010000, -32'sh00008000}};
    load_matrix(m);
    write_matrix_reg(3'd6, '1);
    write_matrix_reg(3'd7, '1);
    send_fields(MODE_RAY, 0, 0, -10 * ONE_FX, 0, 0, ONE_FX);
    send_fields(MODE_NORMAL, ONE_FX, ONE_FX, 0, 0, 0, 0);
    send_random(100);
  endtask

  task automatic test_matrix_extremes();
    logic signed [31:0] m[3][4];
    for (int r = 0; r < 3; r++) for (int k = 0; k < 4; k++) m[r][k] = 32'sh7fffffff;
    load_matrix(m);
    send_random(40);
    for (int r = 0; r < 3; r++) for (int k = 0; k < 4; k++) m[r][k] = 32'sh80000000;
    load_matrix(m);
    send_random(40);
    for (int r = 0; r < 3; r++) for (int k = 0; k < 4; k++) m[r][k] = 0;
    load_matrix(m);
    send_random(20);
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count);
    logic signed [31:0] m[3][4];
    int kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int part = 0; part < 4; part++) begin
      kind = (part == 3) ? $urandom_range(1) : 2;
      for (int r = 0; r < 3; r++) for (int k = 0; k < 4; k++) m[r][k] = rand_mat_elem(kind);
      load_matrix(m);
      send_random(count / 4);
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 300;
    send_random(120);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_mode          = MODE_RAY;
    in_origin_x      = '0;
    in_origin_y      = '0;
    in_origin_z      = '0;
    in_dir_x         = '0;
    in_dir_y         = '0;
    in_dir_z         = '0;
    out_stall        = 1'b0;
    error_count      = 0;
    sent_count       = 0;
    checked_count    = 0;
    hit_count        = 0;
    idle_cycles      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++) inv_mat[r][k] = (r == k) ? longint'(ONE_FX) : 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_directed();
    test_register_writes();
    test_matrix_extremes();
    test_random_phase(18, 63, 600);
    test_random_phase(63, 18, 600);
    test_random_phase(0, 0, 600);
    test_output_backpressure();
    wait_idle();

    $display("Sent %0d ray and normal transactions, checked %0d results (%0d hits).",
             sent_count, checked_count, hit_count);
    $display("Covered identity, scaled, saturating and zero matrices with idling and stalls.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
